>>> hw/rtl/bsra_pkg.sv
// Shared types, constants and register codes for the background subtraction block.
package bsra_pkg;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 17;
    localparam int BG_W    = 16;
    localparam int RATE_W  = 17;
    localparam int COUNT_W = 8;

    // Default frame size and the largest frame the index field can address
    localparam int FRAME_PIXELS_DEF = 131072;
    localparam int IDX_SPAN         = 131072;

    // Q16 unity and rounding constant
    localparam logic [RATE_W-1:0] Q16_ONE  = 17'h10000;
    localparam logic [33:0]       Q16_HALF = 34'd32768;

    // floor(x / 257) == (x * RECIP_257) >> 24 for x below 2^17
    localparam logic [16:0] RECIP_257 = 17'd65281;
    localparam logic [16:0] ROUND_257 = 17'd128;

    // Request kinds carried in tuser
    localparam logic [1:0] ACT_PIXEL   = 2'd0;
    localparam logic [1:0] ACT_CAPTURE = 2'd1;
    localparam logic [1:0] ACT_COUNT   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_AUTO_ENABLE = 2'd0;
    localparam logic [1:0] REG_LEARN_RATE  = 2'd1;
    localparam logic [1:0] REG_DARK_MODE   = 2'd2;

    // Pixel entering the background update pipeline
    typedef struct packed {
        logic             valid;
        logic             capture;
        logic [PIX_W-1:0] pix;
        logic [IDX_W-1:0] idx;
    } pix_req_t;

    // Indexes still in flight ahead of the memory write
    typedef struct packed {
        logic             s1_valid;
        logic [IDX_W-1:0] s1_idx;
        logic             s2_valid;
        logic [IDX_W-1:0] s2_idx;
    } hazard_t;

    // Updated background handed to the difference stage
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
        logic [IDX_W-1:0] idx;
        logic [BG_W-1:0]  bg;
    } bg_res_t;

endpackage

>>> hw/rtl/background_subtract_running_average.sv
// Top level: stream ports, configuration registers, accept and stall control.
// Takes one request per clock unless stalled and returns one result per in-range pixel,
// registered after the update and difference stages; capture and count commands, unused
// kinds and out-of-frame pixels give none. The per-pixel background lives in an on-chip
// memory with a read-modify-write loop: a pixel whose index equals one of the two pixels
// just ahead of it in that loop waits until they have moved on, so sustained rate is one
// pixel per clock for distinct indexes. The background memory is not cleared at reset;
// every entry must be captured once (capture is pending after reset, so the first frame
// does it) before it is meaningful. The pipeline stalls as a whole while the output is held.
module background_subtract_running_average
#(
    parameter int FRAME_PIXELS = bsra_pkg::FRAME_PIXELS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration write port
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [bsra_pkg::RATE_W-1:0]  cfg_data,
    // Request stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [39:0]                  s_axis_tdata,  // pixel, pixel_index, frame_count
    input  logic [1:0]                   s_axis_tuser,  // action
    // Result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata   // difference, result_index
);

    logic                          auto_enable_reg;
    logic [bsra_pkg::RATE_W-1:0]   learn_rate_reg;
    logic                          dark_mode_reg;

    logic [bsra_pkg::PIX_W-1:0]    in_pix;
    logic [bsra_pkg::IDX_W-1:0]    in_idx;
    logic [bsra_pkg::COUNT_W-1:0]  in_count;
    logic                          adv;
    logic                          hazard_hit;
    logic                          accept;
    logic                          is_pixel;
    logic                          in_frame;
    logic                          acc_pixel;
    logic                          frame_start;
    logic                          capture_now;
    logic                          out_valid;
    logic [bsra_pkg::PIX_W-1:0]    out_diff;
    logic [bsra_pkg::IDX_W-1:0]    out_idx;

    bsra_pkg::hazard_t             hazard;
    bsra_pkg::pix_req_t            req;
    bsra_pkg::bg_res_t             res;

    assign in_pix   = s_axis_tdata[7:0];
    assign in_idx   = s_axis_tdata[24:8];
    assign in_count = s_axis_tdata[32:25];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_enable_reg <= 1'b0;
            learn_rate_reg  <= '0;
            dark_mode_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bsra_pkg::REG_AUTO_ENABLE: auto_enable_reg <= cfg_data[0];
                bsra_pkg::REG_LEARN_RATE:  learn_rate_reg  <= cfg_data;
                bsra_pkg::REG_DARK_MODE:   dark_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline moves whenever the output register can take a new result
    assign adv = !out_valid || m_axis_tready;

    // Hold a pixel whose index is still being updated ahead of it
    assign is_pixel   = (s_axis_tuser == bsra_pkg::ACT_PIXEL);
    assign hazard_hit = is_pixel &&
                        ((hazard.s1_valid && (hazard.s1_idx == in_idx)) ||
                         (hazard.s2_valid && (hazard.s2_idx == in_idx)));

    assign s_axis_tready = adv && !hazard_hit;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_frame    = ({15'd0, in_idx} < 32'(FRAME_PIXELS));
    assign acc_pixel   = accept && is_pixel && in_frame;
    assign frame_start = (in_idx == '0);

    bsra_capture u_capture
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc_capture (accept && (s_axis_tuser == bsra_pkg::ACT_CAPTURE)),
        .acc_count   (accept && (s_axis_tuser == bsra_pkg::ACT_COUNT)),
        .count       (in_count),
        .acc_pixel   (acc_pixel),
        .frame_start (frame_start),
        .capture_now (capture_now)
    );

    assign req.valid   = acc_pixel;
    assign req.capture = capture_now;
    assign req.pix     = in_pix;
    assign req.idx     = in_idx;

    bsra_bgupd #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_bgupd
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .req         (req),
        .auto_enable (auto_enable_reg),
        .learn_rate  (learn_rate_reg),
        .hazard      (hazard),
        .res         (res)
    );

    bsra_diff u_diff
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .res       (res),
        .dark_mode (dark_mode_reg),
        .out_valid (out_valid),
        .out_diff  (out_diff),
        .out_idx   (out_idx)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {7'd0, out_idx, out_diff};

endmodule

>>> hw/rtl/bsra_capture.sv
// Capture command sequencing: pending flag, frame countdown and per-frame capture flag.
module bsra_capture
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          acc_capture,
    input  logic                          acc_count,
    input  logic [bsra_pkg::COUNT_W-1:0]  count,
    input  logic                          acc_pixel,
    input  logic                          frame_start,
    output logic                          capture_now
);

    logic                         pending_reg;
    logic                         pending_next;
    logic [bsra_pkg::COUNT_W-1:0] frames_left_reg;
    logic [bsra_pkg::COUNT_W-1:0] frames_left_next;
    logic                         capturing_reg;
    logic                         capturing_next;
    logic                         count_live;

    assign count_live = (frames_left_reg != '0);

    // Capture flag for the pixel being accepted now
    always_comb
    begin
        if (frame_start)
            capture_now = count_live | pending_reg;
        else
            capture_now = capturing_reg;
    end

    // Command and frame start updates
    always_comb
    begin
        pending_next     = pending_reg;
        frames_left_next = frames_left_reg;
        capturing_next   = capturing_reg;
        if (acc_capture)
        begin
            pending_next = 1'b1;
        end
        else if (acc_count)
        begin
            frames_left_next = count;
        end
        else if (acc_pixel && frame_start)
        begin
            if (count_live)
                frames_left_next = frames_left_reg - (bsra_pkg::COUNT_W)'(1);
            capturing_next = count_live | pending_reg;
            pending_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= 1'b1;
            frames_left_reg <= '0;
            capturing_reg   <= 1'b0;
        end
        else
        begin
            pending_reg     <= pending_next;
            frames_left_reg <= frames_left_next;
            capturing_reg   <= capturing_next;
        end
    end

endmodule

>>> hw/rtl/bsra_bgupd.sv
// Background memory and the pipelined running-average update (read, multiply, sum).
module bsra_bgupd
#(
    parameter int FRAME_PIXELS = bsra_pkg::FRAME_PIXELS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  bsra_pkg::pix_req_t           req,
    input  logic                         auto_enable,
    input  logic [bsra_pkg::RATE_W-1:0]  learn_rate,
    output bsra_pkg::hazard_t            hazard,
    output bsra_pkg::bg_res_t            res
);

    localparam int DEPTH = (FRAME_PIXELS < bsra_pkg::IDX_SPAN) ? FRAME_PIXELS
                                                                : bsra_pkg::IDX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [bsra_pkg::BG_W-1:0] mem [DEPTH];

    // Stage 1: read data, forward data, request
    logic [bsra_pkg::BG_W-1:0]  rd_reg;
    logic [bsra_pkg::BG_W-1:0]  fwd_reg;
    logic                       fwd_sel_reg;
    logic                       v1_reg;
    logic                       cap1_reg;
    logic [bsra_pkg::PIX_W-1:0] pix1_reg;
    logic [bsra_pkg::IDX_W-1:0] idx1_reg;

    // Stage 2: products
    logic                       v2_reg;
    logic                       cap2_reg;
    logic [bsra_pkg::PIX_W-1:0] pix2_reg;
    logic [bsra_pkg::IDX_W-1:0] idx2_reg;
    logic [bsra_pkg::BG_W-1:0]  old2_reg;
    logic [32:0]                pa2_reg;
    logic [32:0]                pb2_reg;

    // Stage 3: new background
    logic                       v3_reg;
    logic                       wr3_reg;
    logic [bsra_pkg::PIX_W-1:0] pix3_reg;
    logic [bsra_pkg::IDX_W-1:0] idx3_reg;
    logic [bsra_pkg::BG_W-1:0]  bg3_reg;

    logic [bsra_pkg::BG_W-1:0]   old1;
    logic [bsra_pkg::RATE_W-1:0] rate;
    logic [bsra_pkg::RATE_W-1:0] rate_inv;
    logic [bsra_pkg::BG_W-1:0]   p16;
    logic [32:0]                 pa1;
    logic [32:0]                 pb1;
    logic [33:0]                 sum2;
    logic [17:0]                 sh2;
    logic [bsra_pkg::BG_W-1:0]   blend2;
    logic [bsra_pkg::BG_W-1:0]   bg2;
    logic                        wr2;

    // Memory port: read-first, written from stage 3
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg  <= mem[req.idx[AW-1:0]];
            fwd_reg <= bg3_reg;
            if (v3_reg && wr3_reg)
                mem[idx3_reg[AW-1:0]] <= bg3_reg;
        end
    end

    // Stage 1 multiplies
    always_comb
    begin
        old1     = fwd_sel_reg ? fwd_reg : rd_reg;
        rate     = (learn_rate > bsra_pkg::Q16_ONE) ? bsra_pkg::Q16_ONE : learn_rate;
        rate_inv = bsra_pkg::Q16_ONE - rate;
        p16      = {pix1_reg, pix1_reg};
        pa1      = {17'd0, p16} * {16'd0, rate};
        pb1      = {17'd0, old1} * {16'd0, rate_inv};
    end

    // Stage 2 sum, round, saturate, capture override, old value kept when auto update is off
    always_comb
    begin
        sum2   = {1'b0, pa2_reg} + {1'b0, pb2_reg} + bsra_pkg::Q16_HALF;
        sh2    = sum2[33:16];
        blend2 = (sh2[17:16] != 2'b00) ? 16'hFFFF : sh2[15:0];
        if (cap2_reg)
            bg2 = {pix2_reg, pix2_reg};
        else if (auto_enable)
            bg2 = blend2;
        else
            bg2 = old2_reg;
        wr2 = cap2_reg | auto_enable;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cap1_reg <= req.capture;
            pix1_reg <= req.pix;
            idx1_reg <= req.idx;
            cap2_reg <= cap1_reg;
            pix2_reg <= pix1_reg;
            idx2_reg <= idx1_reg;
            old2_reg <= old1;
            pa2_reg  <= pa1;
            pb2_reg  <= pb1;
            wr3_reg  <= wr2;
            pix3_reg <= pix2_reg;
            idx3_reg <= idx2_reg;
            bg3_reg  <= bg2;
        end
    end

    // Valid bits and forward select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            fwd_sel_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= req.valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            fwd_sel_reg <= v3_reg && (idx3_reg == req.idx);
        end
    end

    assign hazard.s1_valid = v1_reg;
    assign hazard.s1_idx   = idx1_reg;
    assign hazard.s2_valid = v2_reg;
    assign hazard.s2_idx   = idx2_reg;

    assign res.valid = v3_reg;
    assign res.pix   = pix3_reg;
    assign res.idx   = idx3_reg;
    assign res.bg    = bg3_reg;

endmodule

>>> hw/rtl/bsra_diff.sv
// Background scaled to 8 bits, saturating difference and the output register.
module bsra_diff
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  bsra_pkg::bg_res_t            res,
    input  logic                         dark_mode,
    output logic                         out_valid,
    output logic [bsra_pkg::PIX_W-1:0]   out_diff,
    output logic [bsra_pkg::IDX_W-1:0]   out_idx
);

    logic                       v4_reg;
    logic [bsra_pkg::PIX_W-1:0] pix4_reg;
    logic [bsra_pkg::IDX_W-1:0] idx4_reg;
    logic [33:0]                prod4_reg;
    logic                       out_valid_reg;
    logic [bsra_pkg::PIX_W-1:0] out_diff_reg;
    logic [bsra_pkg::IDX_W-1:0] out_idx_reg;

    logic [16:0]                rounded;
    logic [33:0]                prod3;
    logic [bsra_pkg::PIX_W-1:0] bg8;
    logic [bsra_pkg::PIX_W-1:0] diff4;

    // round(bg / 257) as a reciprocal multiply
    always_comb
    begin
        rounded = {1'b0, res.bg} + bsra_pkg::ROUND_257;
        prod3   = {17'd0, rounded} * {17'd0, bsra_pkg::RECIP_257};
    end

    // Saturating difference, direction set by dark mode
    always_comb
    begin
        bg8 = prod4_reg[31:24];
        if (dark_mode)
            diff4 = (bg8 > pix4_reg) ? (bg8 - pix4_reg) : '0;
        else
            diff4 = (pix4_reg > bg8) ? (pix4_reg - bg8) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix4_reg     <= res.pix;
            idx4_reg     <= res.idx;
            prod4_reg    <= prod3;
            out_diff_reg <= diff4;
            out_idx_reg  <= idx4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg        <= res.valid;
            out_valid_reg <= v4_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_diff  = out_diff_reg;
    assign out_idx   = out_idx_reg;

endmodule
